>>> hw/rtl/nfcr_pkg.sv
// Shared types and constants for the frame receiver.
// No dependencies; imported by nfcr_parser and nfc_frame_receiver.
`default_nettype none

package nfcr_pkg;

  localparam logic [1:0] REG_EXPECT_ACK     = 2'd0;
  localparam logic [1:0] REG_EXPECTED_REPLY = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD    = 2'd2;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TIMEOUT   = 4'd1;
  localparam logic [3:0] ST_HEADER    = 4'd2;
  localparam logic [3:0] ST_MISMATCH  = 4'd3;
  localparam logic [3:0] ST_SPACE     = 4'd4;
  localparam logic [3:0] ST_CHECKSUM  = 4'd5;
  localparam logic [3:0] ST_POSTAMBLE = 4'd6;
  localparam logic [3:0] ST_NACK      = 4'd7;
  localparam logic [3:0] ST_BADACK    = 4'd8;

  localparam logic [7:0] DIR_REPLY = 8'hD5;

  typedef struct packed {
    logic        expect_ack;
    logic [7:0]  expected_reply;
    logic [15:0] max_payload;
  } nfcr_cfg_t;

  typedef struct packed {
    logic        is_status;
    logic [7:0]  payload_byte;
    logic [3:0]  status;
    logic [15:0] frame_length;
  } nfcr_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/nfcr_parser.sv
// Per-byte frame parser: start code hunt, ACK frames, header checks, payload and trailer.
// Depends on nfcr_pkg for config/result types and status codes.
`default_nettype none

module nfcr_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [7:0]         rx_byte,
  input  wire logic               timeout,
  input  wire nfcr_pkg::nfcr_cfg_t cfg,
  output logic                    res_valid,
  output nfcr_pkg::nfcr_res_t     res
);
  import nfcr_pkg::*;

  localparam logic [3:0] PH_HUNT  = 4'd0;
  localparam logic [3:0] PH_ACK0  = 4'd1;
  localparam logic [3:0] PH_ACK1  = 4'd2;
  localparam logic [3:0] PH_ACK2  = 4'd3;
  localparam logic [3:0] PH_LEN   = 4'd4;
  localparam logic [3:0] PH_LCS   = 4'd5;
  localparam logic [3:0] PH_DIR   = 4'd6;
  localparam logic [3:0] PH_CMD   = 4'd7;
  localparam logic [3:0] PH_XLENH = 4'd8;
  localparam logic [3:0] PH_XLENL = 4'd9;
  localparam logic [3:0] PH_XLCS  = 4'd10;
  localparam logic [3:0] PH_DATA  = 4'd11;
  localparam logic [3:0] PH_DCS   = 4'd12;
  localparam logic [3:0] PH_POST  = 4'd13;

  logic [3:0]  phase_r, phase_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [15:0] rem_r, rem_nxt;   // pending header status while in header
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  held_r, held_nxt;

  logic        fin;
  logic [3:0]  fin_status;
  logic [15:0] fin_len;
  logic        data_hit;
  logic [15:0] cmd_rem;
  logic [15:0] pay_len;

  assign pay_len = hlen_r - 16'd2;

  always_comb begin
    phase_nxt  = phase_r;
    prev_nxt   = prev_r;
    hlen_nxt   = hlen_r;
    rem_nxt    = rem_r;
    sum_nxt    = sum_r;
    held_nxt   = held_r;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_len    = 16'd0;
    data_hit   = 1'b0;
    cmd_rem    = rem_r;
    if (timeout) begin
      fin        = 1'b1;
      fin_status = ST_TIMEOUT;
    end else begin
      unique case (phase_r)
        PH_ACK0: begin
          held_nxt  = rx_byte;
          phase_nxt = PH_ACK1;
        end
        PH_ACK1: begin
          priority if (held_r == 8'hFF && rx_byte == 8'h00) begin
            held_nxt = 8'(ST_NACK);
          end else if (held_r == 8'h00 && rx_byte == 8'hFF) begin
            held_nxt = 8'(ST_OK);
          end else begin
            held_nxt = 8'(ST_BADACK);
          end
          phase_nxt = PH_ACK2;
        end
        PH_ACK2: begin
          fin        = 1'b1;
          fin_status = (rx_byte != 8'h00) ? ST_BADACK : held_r[3:0];
        end
        PH_LEN: begin
          held_nxt  = rx_byte;
          phase_nxt = PH_LCS;
        end
        PH_LCS: begin
          if (held_r == 8'hFF && rx_byte == 8'hFF) begin
            phase_nxt = PH_XLENH;
          end else begin
            hlen_nxt  = {8'h00, held_r};
            rem_nxt   = ((held_r + rx_byte) != 8'h00) ? 16'(ST_HEADER) : 16'(ST_OK);
            phase_nxt = PH_DIR;
          end
        end
        PH_XLENH: begin
          hlen_nxt  = {rx_byte, 8'h00};
          sum_nxt   = rx_byte;
          phase_nxt = PH_XLENL;
        end
        PH_XLENL: begin
          hlen_nxt  = {hlen_r[15:8], rx_byte};
          sum_nxt   = sum_r + rx_byte;
          phase_nxt = PH_XLCS;
        end
        PH_XLCS: begin
          rem_nxt   = ((sum_r + rx_byte) != 8'h00) ? 16'(ST_HEADER) : 16'(ST_OK);
          phase_nxt = PH_DIR;
        end
        PH_DIR: begin
          if (rem_r == 16'(ST_OK) && rx_byte != DIR_REPLY) rem_nxt = 16'(ST_HEADER);
          phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          if (rem_r == 16'(ST_OK) && rx_byte != cfg.expected_reply) cmd_rem = 16'(ST_MISMATCH);
          priority if (cmd_rem != 16'(ST_OK)) begin
            fin        = 1'b1;
            fin_status = cmd_rem[3:0];
          end else if (hlen_r < 16'd2) begin
            fin        = 1'b1;
            fin_status = ST_HEADER;
          end else if (pay_len > cfg.max_payload) begin
            fin        = 1'b1;
            fin_status = ST_SPACE;
          end else begin
            rem_nxt   = pay_len;
            sum_nxt   = DIR_REPLY + cfg.expected_reply;
            phase_nxt = (pay_len != 16'd0) ? PH_DATA : PH_DCS;
          end
        end
        PH_DATA: begin
          data_hit = 1'b1;
          sum_nxt  = sum_r + rx_byte;
          rem_nxt  = rem_r - 16'd1;
          if (rem_r == 16'd1) phase_nxt = PH_DCS;
        end
        PH_DCS: begin
          held_nxt  = rx_byte;
          phase_nxt = PH_POST;
        end
        PH_POST: begin
          fin = 1'b1;
          priority if ((held_r + sum_r) != 8'h00) begin
            fin_status = ST_CHECKSUM;
          end else if (rx_byte != 8'h00) begin
            fin_status = ST_POSTAMBLE;
          end else begin
            fin_status = ST_OK;
            fin_len    = pay_len;
          end
        end
        default: begin
          if (prev_r == 8'h00 && rx_byte == 8'hFF) begin
            phase_nxt = cfg.expect_ack ? PH_ACK0 : PH_LEN;
            prev_nxt  = 8'hFF;
            rem_nxt   = 16'd0;
            sum_nxt   = 8'h00;
          end else begin
            phase_nxt = PH_HUNT;
            prev_nxt  = rx_byte;
          end
        end
      endcase
    end
    if (fin) begin
      phase_nxt = PH_HUNT;
      prev_nxt  = 8'hFF;
      hlen_nxt  = 16'd0;
      rem_nxt   = 16'd0;
      sum_nxt   = 8'h00;
      held_nxt  = 8'h00;
    end
  end

  always_comb begin
    res_valid        = accept && (fin || data_hit);
    res.is_status    = fin;
    res.payload_byte = fin ? 8'h00 : rx_byte;
    res.status       = fin ? fin_status : ST_OK;
    res.frame_length = fin ? fin_len : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      prev_r  <= 8'hFF;
      hlen_r  <= 16'd0;
      rem_r   <= 16'd0;
      sum_r   <= 8'h00;
      held_r  <= 8'h00;
    end else if (accept) begin
      phase_r <= phase_nxt;
      prev_r  <= prev_nxt;
      hlen_r  <= hlen_nxt;
      rem_r   <= rem_nxt;
      sum_r   <= sum_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/nfc_frame_receiver.sv
// Frame receiver top: config registers, parser and output register with skid.
// Depends on nfcr_pkg and nfcr_parser.
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall   | in_rx_byte, in_timeout
// out     | output    | out_valid/out_stall | out_is_status, out_payload_byte,
//         |           |                     | out_status, out_frame_length, out_last
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat per cycle while in_stall is low; a result goes to the output register, or to skid if out holds.
// in_stall rises only when the output register and the skid register both hold.
// cfg_ready is always high; writes are registered.
// Synchronous active-low reset clears the parser and the output and skid valid flags and loads config defaults.
`default_nettype none

module nfc_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic        in_timeout,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_status,
  output logic [7:0]       out_payload_byte,
  output logic [3:0]       out_status,
  output logic [15:0]      out_frame_length,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import nfcr_pkg::*;

  nfcr_cfg_t cfg_r;
  logic      accept;
  logic      res_valid;
  nfcr_res_t res;
  logic      out_valid_r;
  nfcr_res_t out_r;
  logic      skid_valid_r;
  nfcr_res_t skid_r;
  logic      out_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expect_ack     <= 1'b0;
      cfg_r.expected_reply <= 8'h00;
      cfg_r.max_payload    <= 16'd253;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EXPECT_ACK:     cfg_r.expect_ack     <= cfg_data[0];
        REG_EXPECTED_REPLY: cfg_r.expected_reply <= cfg_data[7:0];
        REG_MAX_PAYLOAD:    cfg_r.max_payload    <= cfg_data;
        default:            ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;

  nfcr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .timeout   (in_timeout),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_pop = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_pop) begin
      out_valid_r <= res_valid;
      out_r       <= res;
    end else if (res_valid) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_status    = out_r.is_status;
  assign out_payload_byte = out_r.payload_byte;
  assign out_status       = out_r.status;
  assign out_frame_length = out_r.frame_length;
  assign out_last         = out_r.is_status;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && !skid_valid_r)
    else $error("skid beat not moved to output");

  a_data_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.is_status |-> out_r.status == ST_OK && out_r.frame_length == 16'd0)
    else $error("payload beat carries status fields");

  a_len_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != ST_OK |-> out_r.frame_length == 16'd0)
    else $error("error status with nonzero length");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.status <= ST_BADACK)
    else $error("status code out of range");

endmodule

`default_nettype wire
